/* design/tile_region_allocator_core_macros.svh */
// assertion helpers used by the allocator rtl
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef TILE_REGION_ALLOCATOR_CORE_MACROS_SVH
`define TILE_REGION_ALLOCATOR_CORE_MACROS_SVH

// condition holds at every clock edge outside reset
`define TRA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg
// types and constants of the tile region allocator
// ----------------------------------------------------------------------------
package tra_pkg;

  localparam int unsigned MaxTiles = 1024;
  localparam int unsigned HdrDepth = MaxTiles + 1;
  localparam int unsigned AddrW    = $clog2(HdrDepth);
  localparam int unsigned HdrW     = 16;
  localparam int unsigned LenW     = 15;
  localparam int unsigned UsedBit  = 15;
  localparam int unsigned CntW     = 11;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_OUTSIDE = 2'd2,
    STAT_ZERO   = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_START_INDEX = 1'b0,
    CFG_REGION_SIZE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] alloc_size;
    logic [11:0] free_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] tile_index;
    logic [10:0] free_total;
    logic [10:0] largest_free;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [HdrW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_FAST_EV,
    S_FF_START,
    S_FF_EV,
    S_FF_END,
    S_SPLIT,
    S_NF_RD,
    S_NF_EV,
    S_MARK,
    S_FREE_EV,
    S_CLR0,
    S_CLR1,
    S_ST_RD,
    S_ST_EV,
    S_DONE
  } state_e;

endpackage

/* design/tra_ram.sv */
// ----------------------------------------------------------------------------
// tra_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tra_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tra_ctrl.sv */
// ----------------------------------------------------------------------------
// tra_ctrl
// request sequencer: walks block headers in memory, merges, splits, counts
// ----------------------------------------------------------------------------
`include "tile_region_allocator_core_macros.svh"

module tra_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tra_pkg::req_t      in_data_i,
  input  logic [10:0]        start_i,
  input  logic [10:0]        rs_i,
  output tra_pkg::mem_req_t  mem_o,
  input  logic [15:0]        mem_rdata_i,
  output logic               rsp_valid_o,
  input  logic               rsp_take_i,
  output tra_pkg::rsp_t      rsp_o
);
  import tra_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0]  best_q, best_d;
  logic [CntW-1:0]   acc_q, acc_d;
  logic [AddrW-1:0]  p_q, p_d;
  logic [CntW-1:0]   blen_q, blen_d;
  logic [15:0]       nf_q, nf_d;
  logic [AddrW-1:0]  fp_q, fp_d;
  logic [CntW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   big_q, big_d;
  logic [1:0]        status_q, status_d;
  logic [11:0]       tile_q, tile_d;

  logic              h_used;
  logic [LenW-1:0]   h_len;
  logic [CntW-1:0]   clen;
  logic [AddrW-1:0]  pos_nx;
  logic [15:0]       nf_nx;
  logic [11:0]       p_end;
  logic [11:0]       free_off;
  logic              free_in;
  logic [CntW-1:0]   sz;

  function automatic logic [CntW-1:0] clamp_len(input logic [AddrW-1:0] pos,
                                                input logic [LenW-1:0]  len,
                                                input logic [AddrW-1:0] rs);
    logic [CntW-1:0] room;
    room = rs - pos;
    clamp_len = ({4'b0, room} < len) ? room : len[CntW-1:0];
  endfunction

  assign h_used   = mem_rdata_i[UsedBit];
  assign h_len    = mem_rdata_i[LenW-1:0];
  assign sz       = req_q.alloc_size;
  assign p_end    = {1'b0, p_q} + {1'b0, sz};
  assign free_off = in_data_i.free_index - {1'b0, start_i};
  assign free_in  = (in_data_i.free_index >= {1'b0, start_i}) && (free_off < {1'b0, rs_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      pos_q    <= '0;
      fp_q     <= '0;
      req_q    <= '0;
      best_q   <= '0;
      acc_q    <= '0;
      p_q      <= '0;
      blen_q   <= '0;
      nf_q     <= '0;
      sum_q    <= '0;
      big_q    <= '0;
      status_q <= '0;
      tile_q   <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      fp_q     <= fp_d;
      req_q    <= req_d;
      best_q   <= best_d;
      acc_q    <= acc_d;
      p_q      <= p_d;
      blen_q   <= blen_d;
      nf_q     <= nf_d;
      sum_q    <= sum_d;
      big_q    <= big_d;
      status_q <= status_d;
      tile_q   <= tile_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    pos_d    = pos_q;
    best_d   = best_q;
    acc_d    = acc_q;
    p_d      = p_q;
    blen_d   = blen_q;
    nf_d     = nf_q;
    fp_d     = fp_q;
    sum_d    = sum_q;
    big_d    = big_q;
    status_d = status_q;
    tile_d   = tile_q;
    mem_o    = '0;
    clen     = clamp_len(pos_q, h_len, rs_i);
    pos_nx   = pos_q + clen;
    nf_nx    = nf_q + {1'b0, h_len};
    rsp_valid_o = 1'b0;

    unique case (state_q)
      S_INIT: begin
        // clearing pass: entry 0 holds the full region, the rest zero
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = (pos_q == '0) ? HdrW'(MaxTiles) : '0;
        pos_d       = pos_q + 1'b1;
        if (pos_q == AddrW'(MaxTiles)) begin
          pos_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          status_d = STAT_OK;
          tile_d   = '0;
          unique case (in_data_i.req_type)
            REQ_ALLOC: begin
              if (in_data_i.alloc_size == '0) begin
                status_d = STAT_ZERO;
                state_d  = S_ST_RD;
              end else if (fp_q < rs_i) begin
                mem_o.re    = 1'b1;
                mem_o.raddr = fp_q;
                state_d     = S_FAST_EV;
              end else begin
                state_d = S_FF_START;
              end
            end
            REQ_FREE: begin
              if (free_in) begin
                mem_o.re    = 1'b1;
                mem_o.raddr = free_off[AddrW-1:0];
                p_d         = free_off[AddrW-1:0];
                state_d     = S_FREE_EV;
              end else begin
                status_d = STAT_OUTSIDE;
                state_d  = S_ST_RD;
              end
            end
            REQ_CLEAR: state_d = S_CLR0;
            default:   state_d = S_ST_RD;
          endcase
        end
      end
      S_FAST_EV: begin
        clen = clamp_len(fp_q, h_len, rs_i);
        if (!h_used && (clen >= sz)) begin
          p_d     = fp_q;
          blen_d  = clen;
          state_d = S_SPLIT;
        end else begin
          state_d = S_FF_START;
        end
      end
      S_FF_START: begin
        pos_d       = '0;
        best_d      = '0;
        acc_d       = '0;
        mem_o.re    = 1'b1;
        mem_o.raddr = '0;
        state_d     = S_FF_EV;
      end
      S_FF_EV: begin
        if (h_len == '0) begin
          state_d = S_FF_END;
        end else if (h_used) begin
          pos_d  = pos_nx;
          best_d = pos_nx;
          if (acc_q != '0) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = best_q;
            mem_o.wdata = {5'b0, acc_q};
            acc_d       = '0;
          end
          if ((acc_q != '0) && (acc_q >= sz)) begin
            p_d     = best_q;
            blen_d  = acc_q;
            state_d = S_SPLIT;
          end else if (pos_nx < rs_i) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = pos_nx;
          end else begin
            state_d = S_FF_END;
          end
        end else begin
          // free block folds into the run, its header goes away
          acc_d       = acc_q + clen;
          mem_o.we    = 1'b1;
          mem_o.waddr = pos_q;
          mem_o.wdata = '0;
          pos_d       = pos_nx;
          if (pos_nx < rs_i) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = pos_nx;
          end else begin
            state_d = S_FF_END;
          end
        end
      end
      S_FF_END: begin
        if ((acc_q != '0) && (best_q < rs_i)) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = best_q;
          mem_o.wdata = {5'b0, acc_q};
        end
        if ((acc_q != '0) && (best_q < rs_i) && (acc_q >= sz)) begin
          p_d     = best_q;
          blen_d  = acc_q;
          state_d = S_SPLIT;
        end else begin
          status_d = STAT_NO_FIT;
          state_d  = S_ST_RD;
        end
      end
      S_SPLIT: begin
        if (blen_q > sz) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = p_end[AddrW-1:0];
          mem_o.wdata = {5'b0, blen_q - sz};
          fp_d        = p_end[AddrW-1:0];
          state_d     = S_MARK;
        end else begin
          nf_d    = {4'b0, p_end};
          state_d = S_NF_RD;
        end
      end
      S_NF_RD: begin
        if (nf_q >= {5'b0, rs_i}) begin
          fp_d    = rs_i;
          state_d = S_MARK;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = nf_q[AddrW-1:0];
          state_d     = S_NF_EV;
        end
      end
      S_NF_EV: begin
        if (!h_used || (h_len == '0)) begin
          fp_d    = nf_q[AddrW-1:0];
          state_d = S_MARK;
        end else begin
          nf_d = nf_nx;
          if (nf_nx < {5'b0, rs_i}) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = nf_nx[AddrW-1:0];
          end else begin
            fp_d    = rs_i;
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = p_q;
        mem_o.wdata = {1'b1, 4'b0, sz};
        tile_d      = {1'b0, start_i} + {1'b0, p_q};
        state_d     = S_ST_RD;
      end
      S_FREE_EV: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = p_q;
        mem_o.wdata = {1'b0, h_len};
        state_d     = S_ST_RD;
      end
      S_CLR0: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = '0;
        mem_o.wdata = {5'b0, rs_i};
        fp_d        = '0;
        state_d     = S_CLR1;
      end
      S_CLR1: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = rs_i;
        mem_o.wdata = '0;
        state_d     = S_ST_RD;
      end
      S_ST_RD: begin
        pos_d       = '0;
        sum_d       = '0;
        big_d       = '0;
        mem_o.re    = 1'b1;
        mem_o.raddr = '0;
        state_d     = S_ST_EV;
      end
      S_ST_EV: begin
        if (h_len == '0) begin
          state_d = S_DONE;
        end else begin
          if (!h_used) begin
            sum_d = sum_q + clen;
            if (clen > big_q) begin
              big_d = clen;
            end
          end
          pos_d = pos_nx;
          if (pos_nx < rs_i) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = pos_nx;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign rsp_o.status        = status_q;
  assign rsp_o.tile_index    = tile_q;
  assign rsp_o.free_total    = sum_q;
  assign rsp_o.largest_free  = big_q;

  `TRA_ASSERT(a_no_rw_same_entry,
    !(mem_o.we && mem_o.re && (mem_o.waddr == mem_o.raddr)),
    "header read and write hit the same entry")
  `TRA_ASSERT(a_fp_in_range, fp_q <= AddrW'(MaxTiles), "free pointer beyond memory")
  `TRA_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o,
    state_q != S_IDLE, "accepted item left no work")
  `TRA_ASSERT_IMP(a_split_fits, state_q == S_SPLIT,
    (blen_q >= sz) && ({1'b0, p_q} + {1'b0, blen_q} <= {1'b0, rs_i}),
    "chosen block too small or past region end")

endmodule

/* design/tile_region_allocator_core.sv */
// ----------------------------------------------------------------------------
// tile_region_allocator_core
// first-fit tile allocator with boundary tag headers and lazy merging
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  in       | input     | in_valid_i / in_stall_o   | in_data_i   (req_t)
//  out      | output    | out_valid_o / out_stall_i | out_data_o  (rsp_t)
//  cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// one item at a time; each header visited takes a read on the single read
// port of the header memory: the fast-path check, the first-fit pass, the
// next-free walk and the statistics walk each read headers this way
// after reset a clearing pass writes all 1025 headers with in_stall_o high
// a new item is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module tile_region_allocator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tra_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tra_pkg::rsp_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [10:0]    cfg_wdata_i
);
  import tra_pkg::*;

  logic [10:0]  start_q;
  logic [10:0]  size_q;
  logic [10:0]  rs;
  mem_req_t     mem_req;
  logic [15:0]  mem_rdata;
  logic         rsp_valid;
  logic         rsp_take;
  rsp_t         rsp;
  logic         out_valid_q, out_valid_d;
  rsp_t         out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      size_q  <= 11'(MaxTiles);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_INDEX: start_q <= cfg_wdata_i;
        CFG_REGION_SIZE: size_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero acts as one tile, oversize as the whole memory
  always_comb begin
    priority if (size_q == '0) begin
      rs = 11'd1;
    end else if (size_q > 11'(MaxTiles)) begin
      rs = 11'(MaxTiles);
    end else begin
      rs = size_q;
    end
  end

  tra_ram #(
    .Width (HdrW),
    .Depth (HdrDepth)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  tra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .start_i     (start_q),
    .rs_i        (rs),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .rsp_valid_o (rsp_valid),
    .rsp_take_i  (rsp_take),
    .rsp_o       (rsp)
  );

  assign rsp_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_take) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tile region allocator: a directed table of
// requests, then randomized alloc/free/clear traffic over several region
// settings, results checked against typed rows or a copy of the allocator
// ----------------------------------------------------------------------------
module tb;
  import tra_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  req_t in_data_i;
  rsp_t out_data_o;
  logic [0:0] cfg_idx_i;
  logic [10:0] cfg_wdata_i;

  tile_region_allocator_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    req_t r;
    bit typed;
    rsp_t e;
  } dir_row_t;

  // allocator state as seen by the bench
  logic [15:0] hdr_mem [0:MaxTiles];
  int unsigned free_ptr, cur_start, cur_size;

  rsp_t rsp_q[$];
  int unsigned live_tiles[$];
  int errors = 0, n_items = 0, n_rsp = 0, n_fail_alloc = 0;
  bit quiet = 0, hold_req = 0, hold_done = 0;
  bit cur_typed;
  rsp_t cur_exp;

  function automatic int unsigned eff_size();
    if (cur_size == 0) return 1;
    if (cur_size > MaxTiles) return MaxTiles;
    return cur_size;
  endfunction

  function automatic int unsigned clamp_len(int unsigned pos, int unsigned len,
                                            int unsigned rs);
    return (len > rs - pos) ? rs - pos : len;
  endfunction

  // merge free runs up to the first one that holds need tiles
  function automatic bit merge_fit(int unsigned need, output int unsigned where);
    int unsigned rs, pos, best, acc, len;
    logic [15:0] h;
    rs = eff_size();
    pos = 0; best = 0; acc = 0; where = 0;
    while (pos < rs) begin
      h = hdr_mem[pos];
      len = 32'(h[14:0]);
      if (len == 0) break;
      len = clamp_len(pos, len, rs);
      if (h[UsedBit]) begin
        if (acc != 0) begin
          hdr_mem[best] = acc[15:0];
          if (acc >= need) begin
            where = best;
            return 1;
          end
          acc = 0;
        end
        pos += len;
        best = pos;
      end else begin
        acc += len;
        hdr_mem[pos] = '0;
        pos += len;
      end
    end
    if (acc != 0 && best < rs) begin
      hdr_mem[best] = acc[15:0];
      if (acc >= need) begin
        where = best;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void clear_headers();
    int unsigned rs;
    rs = eff_size();
    hdr_mem[0] = rs[15:0];
    hdr_mem[rs] = '0;
    free_ptr = 0;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    int unsigned rs, size, fidx, p, blen, nf, len, sum, big, pos;
    logic [15:0] h;
    bit ok;
    rs = eff_size();
    size = 32'(r.alloc_size);
    fidx = 32'(r.free_index);
    o = '0;
    case (req_type_e'(r.req_type))
      REQ_ALLOC: begin
        if (size == 0) begin
          o.status = STAT_ZERO;
        end else begin
          ok = 0;
          p = 0;
          if (free_ptr < rs) begin
            h = hdr_mem[free_ptr];
            if (!h[UsedBit] && clamp_len(free_ptr, 32'(h[14:0]), rs) >= size) begin
              p = free_ptr;
              ok = 1;
            end
          end
          if (!ok) ok = merge_fit(size, p);
          if (!ok) begin
            o.status = STAT_NO_FIT;
          end else begin
            blen = clamp_len(p, 32'(hdr_mem[p][14:0]), rs);
            nf = p + size;
            if (blen > size) begin
              hdr_mem[nf] = 16'(blen - size);
            end else begin
              while (nf < rs) begin
                h = hdr_mem[nf];
                len = 32'(h[14:0]);
                if (!h[UsedBit] || len == 0) break;
                nf += len;
              end
              if (nf > rs) nf = rs;
            end
            free_ptr = nf;
            hdr_mem[p] = 16'(size) | 16'h8000;
            o.tile_index = 12'(cur_start + p);
          end
        end
      end
      REQ_FREE: begin
        if (fidx >= cur_start && fidx - cur_start < rs)
          hdr_mem[fidx - cur_start][UsedBit] = 1'b0;
        else
          o.status = STAT_OUTSIDE;
      end
      REQ_CLEAR: clear_headers();
      default: ;
    endcase
    pos = 0; sum = 0; big = 0;
    while (pos < rs) begin
      h = hdr_mem[pos];
      len = 32'(h[14:0]);
      if (len == 0) break;
      len = clamp_len(pos, len, rs);
      if (!h[UsedBit]) begin
        sum += len;
        if (len > big) big = len;
      end
      pos += len;
    end
    o.free_total = sum[10:0];
    o.largest_free = big[10:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // accepted requests
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      e = serve_request(in_data_i);
      if (e.status == STAT_OK && in_data_i.req_type == REQ_ALLOC)
        live_tiles.push_back(32'(e.tile_index));
      if (e.status == STAT_NO_FIT) n_fail_alloc++;
      if (in_data_i.req_type == REQ_CLEAR) live_tiles.delete();
      rsp_q.push_back(cur_typed ? cur_exp : e);
      n_items++;
    end
  end

  // accepted results
  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_rsp++;
      if (rsp_q.size() == 0) begin
        report_mismatch("result count", n_rsp, n_items);
      end else begin
        w = rsp_q.pop_front();
        if (out_data_o.status !== w.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(w.status));
        if (out_data_o.tile_index !== w.tile_index)
          report_mismatch("tile_index", 32'(out_data_o.tile_index), 32'(w.tile_index));
        if (out_data_o.free_total !== w.free_total)
          report_mismatch("free_total", 32'(out_data_o.free_total), 32'(w.free_total));
        if (out_data_o.largest_free !== w.largest_free)
          report_mismatch("largest_free", 32'(out_data_o.largest_free),
                          32'(w.largest_free));
      end
    end
  end

  // receiver: short stall bursts, one long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_done = 1;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // called and returns on a falling edge
  task automatic send_item(req_t r, bit typed = 0, rsp_t e = '0);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    cur_typed = typed;
    cur_exp = e;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v[10:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_START_INDEX) cur_start = 32'(v[10:0]);
    else cur_size = 32'(v[10:0]);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (rsp_q.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic req_t mk_req(req_type_e t, int unsigned sz, int unsigned fi);
    req_t r;
    r.req_type = t;
    r.alloc_size = sz[10:0];
    r.free_index = fi[11:0];
    return r;
  endfunction

  function automatic dir_row_t row(req_type_e t, int unsigned sz, int unsigned fi,
                                   bit typed = 0, status_e s = STAT_OK,
                                   int unsigned ti = 0, int unsigned ft = 0,
                                   int unsigned lf = 0);
    dir_row_t d;
    d.r = mk_req(t, sz, fi);
    d.typed = typed;
    d.e.status = s;
    d.e.tile_index = ti[11:0];
    d.e.free_total = ft[10:0];
    d.e.largest_free = lf[10:0];
    return d;
  endfunction

  function automatic req_t rand_req();
    int unsigned rs, roll, k;
    req_t r;
    rs = eff_size();
    roll = $urandom_range(0, 99);
    r = mk_req(REQ_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 4095));
    if (roll < 50) begin
      k = $urandom_range(0, 19);
      if (k == 0) r.alloc_size = 11'($urandom_range(1, 2047));
      else if (k < 4) r.alloc_size = 11'($urandom_range(1, rs));
      else r.alloc_size = 11'($urandom_range(1, rs > 4 ? rs / 4 : 1));
    end else if (roll < 80) begin
      r.req_type = REQ_FREE;
      if (live_tiles.size() != 0) begin
        k = $urandom_range(0, live_tiles.size() - 1);
        r.free_index = 12'(live_tiles[k]);
        live_tiles.delete(k);
      end
    end else if (roll < 84) begin
      r.req_type = REQ_CLEAR;
    end else if (roll < 92) begin
      r.req_type = REQ_FREE;
    end else if (roll < 96) begin
      r.alloc_size = '0;
    end else begin
      r.req_type = REQ_NONE;
    end
    return r;
  endfunction

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", rsp_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    int unsigned ph_start[7] = '{0, 2047, 100, 1500, 7, 1024, 333};
    int unsigned ph_size[7]  = '{1024, 0, 16, 2047, 48, 1, 100};
    int unsigned ph_items[7] = '{25, 12, 60, 15, 80, 15, 60};

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_START_INDEX;
    cfg_wdata_i = '0;
    for (int i = 0; i <= MaxTiles; i++) hdr_mem[i] = '0;
    cur_start = 0;
    cur_size = MaxTiles;
    clear_headers();

    // results that follow straight from the reset state
    dir_tab.push_back(row(REQ_ALLOC, 0, 0, 1, STAT_ZERO, 0, 1024, 1024));
    dir_tab.push_back(row(REQ_FREE, 0, 4095, 1, STAT_OUTSIDE, 0, 1024, 1024));
    dir_tab.push_back(row(REQ_NONE, 2047, 4095, 1, STAT_OK, 0, 1024, 1024));
    dir_tab.push_back(row(REQ_ALLOC, 1024, 0, 1, STAT_OK, 0, 0, 0));
    dir_tab.push_back(row(REQ_ALLOC, 1, 0, 1, STAT_NO_FIT, 0, 0, 0));
    dir_tab.push_back(row(REQ_FREE, 0, 0, 1, STAT_OK, 0, 1024, 1024));
    dir_tab.push_back(row(REQ_ALLOC, 2047, 0, 1, STAT_NO_FIT, 0, 1024, 1024));
    dir_tab.push_back(row(REQ_ALLOC, 1, 0, 1, STAT_OK, 0, 1023, 1023));
    dir_tab.push_back(row(REQ_FREE, 0, 1024, 1, STAT_OUTSIDE, 0, 1023, 1023));
    // split, free in the middle, merge on the first-fit pass
    dir_tab.push_back(row(REQ_ALLOC, 10, 0));
    dir_tab.push_back(row(REQ_ALLOC, 5, 0));
    dir_tab.push_back(row(REQ_ALLOC, 7, 0));
    dir_tab.push_back(row(REQ_FREE, 0, 1));
    dir_tab.push_back(row(REQ_FREE, 0, 11));
    dir_tab.push_back(row(REQ_FREE, 0, 0));
    dir_tab.push_back(row(REQ_ALLOC, 1000, 0));
    dir_tab.push_back(row(REQ_ALLOC, 14, 0));
    dir_tab.push_back(row(REQ_FREE, 0, 3));
    dir_tab.push_back(row(REQ_ALLOC, 20, 0));
    dir_tab.push_back(row(REQ_FREE, 0, 4));
    dir_tab.push_back(row(REQ_CLEAR, 0, 0));
    dir_tab.push_back(row(REQ_ALLOC, 1023, 0));
    dir_tab.push_back(row(REQ_ALLOC, 1, 0));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    // let the clearing pass after reset finish
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].e);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) begin
        drain();
        cfg_write(CFG_START_INDEX, ph_start[ph]);
        cfg_write(CFG_REGION_SIZE, ph_size[ph]);
        live_tiles.delete();
      end
      if (ph == 6) quiet = 1;
      for (int k = 0; k < ph_items[ph]; k++) begin
        if (ph == 4 && k == 10) hold_req = 1;
        send_item(rand_req());
      end
    end

    drain();
    $display("%0d requests over 7 region settings, %0d results checked", n_items, n_rsp);
    $display("%0d allocations found no fitting block; %0d errors", n_fail_alloc, errors);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
